/* rtl/core/cbmp_pkg.sv */
// Shared constants, types and helper functions for the complex bin magnitude and phase block.
package cbmp_pkg;

  localparam int unsigned SampleWidthDefault   = 24;
  localparam int unsigned AngleFracBitsDefault = 13;

  // The angle accumulator counts units of 2^-30 rad.
  localparam int unsigned CordicSteps = 30;
  localparam int unsigned AccFrac     = 30;
  localparam int unsigned AccWidth    = 32;

  // Vectors are scaled up until the larger part reaches 2^NormExp.
  localparam int unsigned NormExp     = 40;
  localparam int unsigned CordicWidth = NormExp + 5;

  localparam logic signed [AccWidth-1:0] HalfPiAcc = 32'sd1686629713;

  // Register stages in front of and behind the iteration chains.
  localparam int unsigned MagPreStages   = 3;
  localparam int unsigned PhasePreStages = 4;
  localparam int unsigned PhasePostStages = 3;
  localparam int unsigned PhaseLatency   = PhasePreStages + CordicSteps + PhasePostStages;

  // Control that travels along the phase pipeline next to the data.
  typedef struct packed {
    logic last;
    logic im_zero;
    logic re_zero;
  } ph_ctl_t;

  function automatic int unsigned mag_latency(input int unsigned sample_width);
    mag_latency = MagPreStages + sample_width;
  endfunction

  // Both paths are padded to this depth, so every item leaves in order.
  function automatic int unsigned total_latency(input int unsigned sample_width);
    int unsigned lm;
    lm = mag_latency(sample_width);
    total_latency = ((lm > PhaseLatency) ? lm : PhaseLatency) + 1;
  endfunction

  // atan(2^-i) in units of 2^-30 rad.
  function automatic logic signed [AccWidth-1:0] atan_step(input int unsigned i);
    case (i)
      0: atan_step = 32'sd843314857;
      1: atan_step = 32'sd497837829;
      2: atan_step = 32'sd263043837;
      3: atan_step = 32'sd133525159;
      4: atan_step = 32'sd67021687;
      5: atan_step = 32'sd33543516;
      6: atan_step = 32'sd16775851;
      7: atan_step = 32'sd8388437;
      8: atan_step = 32'sd4194283;
      9: atan_step = 32'sd2097149;
      default: atan_step = AccWidth'(64'sd1 <<< (AccFrac - i));
    endcase
  endfunction

endpackage

/* rtl/core/cbmp_dly.sv */
// Valid-qualified register delay line used to align the two result paths.
module cbmp_dly import cbmp_pkg::*; #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [DEPTH-1:0] vld_q;
  logic [WIDTH-1:0] data_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q[0] <= valid_i;
      for (int unsigned k = 1; k < DEPTH; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q[0] <= data_i;
    end
    for (int unsigned k = 1; k < DEPTH; k++) begin
      if (vld_q[k-1]) begin
        data_q[k] <= data_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[DEPTH-1];
  assign data_o  = data_q[DEPTH-1];

endmodule

/* rtl/core/cbmp_mag.sv */
// Magnitude pipeline: absolute values, squares, sum and a one-bit-per-stage square root.
module cbmp_mag import cbmp_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic signed [SAMPLE_WIDTH-1:0] real_part_i,
  input  logic signed [SAMPLE_WIDTH-1:0] imag_part_i,
  output logic                           valid_o,
  output logic        [SAMPLE_WIDTH-1:0] magnitude_o
);

  localparam int unsigned SW  = SAMPLE_WIDTH;
  localparam int unsigned Lat = MagPreStages + SW;

  logic [Lat-1:0] vld_q;

  logic [SW-1:0]   ar_q, ai_q;
  logic [SW-1:0]   ar_d, ai_d;
  logic [2*SW-1:0] sqr_q, sqi_q;

  logic [2*SW-1:0] rad_q  [SW];
  logic [SW+1:0]   rem_q  [SW];
  logic [SW-1:0]   root_q [SW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], valid_i};
    end
  end

  // The negation of the most negative value wraps to the right unsigned bits.
  assign ar_d = $unsigned(real_part_i[SW-1] ? -real_part_i : real_part_i);
  assign ai_d = $unsigned(imag_part_i[SW-1] ? -imag_part_i : imag_part_i);

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      ar_q <= ar_d;
      ai_q <= ai_d;
    end
    if (vld_q[0]) begin
      sqr_q <= (2*SW)'(ar_q) * (2*SW)'(ar_q);
      sqi_q <= (2*SW)'(ai_q) * (2*SW)'(ai_q);
    end
    if (vld_q[1]) begin
      rad_q[0]  <= sqr_q + sqi_q;
      rem_q[0]  <= '0;
      root_q[0] <= '0;
    end
  end

  for (genvar j = 0; j < SW; j++) begin : g_sqrt
    logic [SW+1:0] rem_pre;
    logic [SW+1:0] trial;
    logic [SW+2:0] diff;
    logic          ge;

    always_comb begin
      rem_pre = {rem_q[j][SW-1:0], rad_q[j][2*SW-1 -: 2]};
      trial   = {root_q[j], 2'b01};
      diff    = {1'b0, rem_pre} - {1'b0, trial};
      ge      = ~diff[SW+2];
    end

    always_ff @(posedge clk_i) begin
      if (vld_q[MagPreStages-1+j]) begin
        root_q[j+1] <= {root_q[j][SW-2:0], ge};
      end
    end

    if (j < SW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (vld_q[MagPreStages-1+j]) begin
          rad_q[j+1] <= rad_q[j] << 2;
          rem_q[j+1] <= ge ? diff[SW+1:0] : rem_pre;
        end
      end
    end
  end

  assign valid_o     = vld_q[Lat-1];
  assign magnitude_o = root_q[SW];

endmodule

/* rtl/core/cbmp_phase.sv */
// Phase pipeline: fold to the right half plane, normalize, CORDIC vectoring and rounding.
module cbmp_phase import cbmp_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH    = SampleWidthDefault,
  parameter int unsigned ANGLE_FRAC_BITS = AngleFracBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    real_part_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    imag_part_i,
  input  logic                              last_i,
  output logic                              valid_o,
  output logic signed [ANGLE_FRAC_BITS+1:0] phase_o,
  output logic                              last_o
);

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned PhW   = ANGLE_FRAC_BITS + 2;
  localparam int unsigned PW    = $clog2(SW);
  localparam int unsigned KW    = $clog2(NormExp + 1);
  localparam int unsigned CW    = CordicWidth;
  localparam int unsigned Shift = AccFrac - ANGLE_FRAC_BITS;
  localparam int unsigned Lat   = PhaseLatency;
  localparam logic [AccWidth:0] RoundHalf = (AccWidth+1)'(1) << (Shift - 1);

  logic [Lat-1:0] vld_q;
  ph_ctl_t        ctl_q [Lat];

  logic signed [SW:0] re_ext, im_ext;
  logic signed [SW:0] x1_q, y1_q, x2_q, y2_q, x3_q, y3_q;
  logic signed [SW:0] ay;
  logic [SW-1:0]      m2_q;
  logic [PW-1:0]      msb;
  logic [KW-1:0]      k3_q;

  logic signed [CW-1:0]       cx_q [CordicSteps+1];
  logic signed [CW-1:0]       cy_q [CordicSteps+1];
  logic signed [AccWidth-1:0] cz_q [CordicSteps+1];

  logic signed [AccWidth-1:0] zsel;
  logic [AccWidth-1:0]        r1_mag_q;
  logic                       r1_neg_q, r2_neg_q;
  logic [AccWidth:0]          rnd_sum;
  logic [PhW-1:0]             r2_q;
  logic signed [PhW-1:0]      r3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      ctl_q[0] <= '{last: last_i, im_zero: (imag_part_i == '0), re_zero: (real_part_i == '0)};
    end
    for (int unsigned k = 1; k < Lat; k++) begin
      if (vld_q[k-1]) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
  end

  assign re_ext = (SW+1)'(real_part_i);
  assign im_ext = (SW+1)'(imag_part_i);
  assign ay     = y1_q[SW] ? -y1_q : y1_q;

  always_comb begin
    msb = '0;
    for (int unsigned b = 0; b < SW; b++) begin
      if (m2_q[b]) begin
        msb = PW'(b);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // atan(im/re) is unchanged when both parts flip sign.
    if (valid_i) begin
      x1_q <= real_part_i[SW-1] ? -re_ext : re_ext;
      y1_q <= real_part_i[SW-1] ? -im_ext : im_ext;
    end
    if (vld_q[0]) begin
      x2_q <= x1_q;
      y2_q <= y1_q;
      m2_q <= (x1_q > ay) ? x1_q[SW-1:0] : ay[SW-1:0];
    end
    if (vld_q[1]) begin
      x3_q <= x2_q;
      y3_q <= y2_q;
      k3_q <= KW'(NormExp) - KW'(msb);
    end
    if (vld_q[2]) begin
      cx_q[0] <= CW'(x3_q) <<< k3_q;
      cy_q[0] <= CW'(y3_q) <<< k3_q;
      cz_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
    logic signed [CW-1:0]       dx, dy;
    logic signed [AccWidth-1:0] ang;

    always_comb begin
      dx  = cy_q[i] >>> i;
      dy  = cx_q[i] >>> i;
      ang = atan_step(i);
    end

    always_ff @(posedge clk_i) begin
      if (vld_q[PhasePreStages-1+i]) begin
        if (!cy_q[i][CW-1]) begin
          cx_q[i+1] <= cx_q[i] + dx;
          cy_q[i+1] <= cy_q[i] - dy;
          cz_q[i+1] <= cz_q[i] + ang;
        end else begin
          cx_q[i+1] <= cx_q[i] - dx;
          cy_q[i+1] <= cy_q[i] + dy;
          cz_q[i+1] <= cz_q[i] - ang;
        end
      end
    end
  end

  // Special cases override the rotation result before rounding.
  always_comb begin
    if (ctl_q[Lat-4].im_zero) begin
      zsel = '0;
    end else if (ctl_q[Lat-4].re_zero) begin
      zsel = HalfPiAcc;
    end else begin
      zsel = cz_q[CordicSteps];
    end
  end

  assign rnd_sum = {1'b0, r1_mag_q} + RoundHalf;

  always_ff @(posedge clk_i) begin
    if (vld_q[Lat-4]) begin
      r1_neg_q <= zsel[AccWidth-1];
      r1_mag_q <= $unsigned(zsel[AccWidth-1] ? -zsel : zsel);
    end
    if (vld_q[Lat-3]) begin
      r2_neg_q <= r1_neg_q;
      r2_q     <= PhW'(rnd_sum >> Shift);
    end
    if (vld_q[Lat-2]) begin
      r3_q <= r2_neg_q ? -$signed(r2_q) : $signed(r2_q);
    end
  end

  assign valid_o = vld_q[Lat-1];
  assign phase_o = r3_q;
  assign last_o  = ctl_q[Lat-1].last;

endmodule

/* rtl/core/complex_bin_magnitude_phase.sv */
// Top level of the complex bin magnitude and phase block.
//
// This block turns one complex spectrum bin per clock into polar form: the
// magnitude floor(sqrt(re^2 + im^2)), exact to the bit, and the phase
// atan(im/re) in radians scaled by 2^ANGLE_FRAC_BITS, which stays within
// -pi/2..pi/2 (it is not a four-quadrant angle). A zero imaginary part gives
// phase zero; a zero real part with a nonzero imaginary part gives +pi/2. A
// transaction is taken at every rising edge where start_i is high and busy_o
// is low; busy_o never rises, so a new bin can be offered in every cycle. Each
// result appears on magnitude_o, phase_o and last_out_o for exactly one cycle
// with done_o high, in the order the bins came in. The receiver cannot hold
// results off and none is ever dropped. The latency is set by the longer of
// two pipelines: the 30-stage CORDIC vectoring chain of the phase path plus
// its normalization and rounding stages, and the square root of the magnitude
// path, which resolves one result bit per stage. Both paths are padded to the
// same depth. The sustained rate is one transaction per cycle.
module complex_bin_magnitude_phase import cbmp_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH    = SampleWidthDefault,
  parameter int unsigned ANGLE_FRAC_BITS = AngleFracBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [SAMPLE_WIDTH-1:0]    real_part_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    imag_part_i,
  input  logic                              last_bin_i,
  output logic                              done_o,
  output logic        [SAMPLE_WIDTH-1:0]    magnitude_o,
  output logic signed [ANGLE_FRAC_BITS+1:0] phase_o,
  output logic                              last_out_o
);

  localparam int unsigned PhW    = ANGLE_FRAC_BITS + 2;
  localparam int unsigned LatMag = mag_latency(SAMPLE_WIDTH);
  localparam int unsigned LatAll = total_latency(SAMPLE_WIDTH);

  logic                    accept;
  logic                    mag_valid, ph_valid;
  logic [SAMPLE_WIDTH-1:0] mag_raw;
  logic signed [PhW-1:0]   ph_raw;
  logic                    ph_last;
  logic                    mag_dly_valid, ph_dly_valid;
  logic [PhW:0]            ph_dly_data;

  // Every stage advances on each clock, so the block never pushes back.
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  cbmp_mag #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_mag (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .real_part_i (real_part_i),
    .imag_part_i (imag_part_i),
    .valid_o     (mag_valid),
    .magnitude_o (mag_raw)
  );

  cbmp_phase #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_phase (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .real_part_i (real_part_i),
    .imag_part_i (imag_part_i),
    .last_i      (last_bin_i),
    .valid_o     (ph_valid),
    .phase_o     (ph_raw),
    .last_o      (ph_last)
  );

  // The alignment stages also serve as the output registers.
  cbmp_dly #(
    .WIDTH(SAMPLE_WIDTH),
    .DEPTH(LatAll - LatMag)
  ) u_mag_dly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mag_valid),
    .data_i  (mag_raw),
    .valid_o (mag_dly_valid),
    .data_o  (magnitude_o)
  );

  cbmp_dly #(
    .WIDTH(PhW + 1),
    .DEPTH(LatAll - PhaseLatency)
  ) u_ph_dly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ph_valid),
    .data_i  ({ph_raw, ph_last}),
    .valid_o (ph_dly_valid),
    .data_o  (ph_dly_data)
  );

  // Both paths carry the same valid pattern; either alone would do.
  assign done_o     = mag_dly_valid & ph_dly_valid;
  assign phase_o    = ph_dly_data[PhW:1];
  assign last_out_o = ph_dly_data[0];

endmodule

/* rtl/core/cbmp_chk.sv */
// Port-level checker for the complex bin magnitude and phase block, with its bind.
module cbmp_chk import cbmp_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH    = SampleWidthDefault,
  parameter int unsigned ANGLE_FRAC_BITS = AngleFracBitsDefault
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start_i,
  input logic                              busy_o,
  input logic signed [SAMPLE_WIDTH-1:0]    imag_part_i,
  input logic                              last_bin_i,
  input logic                              done_o,
  input logic signed [ANGLE_FRAC_BITS+1:0] phase_o,
  input logic                              last_out_o
);

  localparam int unsigned PhW   = ANGLE_FRAC_BITS + 2;
  localparam int unsigned Lat   = total_latency(SAMPLE_WIDTH);
  localparam int unsigned Shift = AccFrac - ANGLE_FRAC_BITS;
  localparam longint HalfPiOut =
    (longint'(HalfPiAcc) + (longint'(1) << (Shift - 1))) >>> Shift;
  localparam logic signed [PhW-1:0] PhaseMax = PhW'(HalfPiOut);

  // A result only ever follows a transaction taken the fixed latency earlier.
  a_done_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, Lat))
    else $error("result without a matching input transaction");

  a_last_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (last_out_o == $past(last_bin_i, Lat)))
    else $error("last flag does not match its input transaction");

  a_im_zero_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(imag_part_i == '0, Lat)) |-> (phase_o == '0))
    else $error("zero imaginary part gave a nonzero phase");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((phase_o <= PhaseMax) && (phase_o >= -PhaseMax)))
    else $error("phase outside -pi/2..pi/2");

endmodule

bind complex_bin_magnitude_phase cbmp_chk #(
  .SAMPLE_WIDTH   (SAMPLE_WIDTH),
  .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
) u_cbmp_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .imag_part_i (imag_part_i),
  .last_bin_i  (last_bin_i),
  .done_o      (done_o),
  .phase_o     (phase_o),
  .last_out_o  (last_out_o)
);

/* verif/tb_complex_bin_magnitude_phase.sv */
// Testbench for the complex bin magnitude and phase block, with its own bit-exact predictor.
`timescale 1ns / 100ps

module tb_complex_bin_magnitude_phase;
  import cbmp_pkg::*;

  localparam int unsigned SW = SampleWidthDefault;
  localparam int unsigned AFB = AngleFracBitsDefault;
  localparam int unsigned PW = AFB + 2;

  // The phase accumulator counts units of 2^-30 rad. Its value for pi/2 and the
  // arctangents of the first ten CORDIC steps are listed here; later steps use
  // the small-angle value 2^(30-i).
  localparam int unsigned AngleUnitBits = 30;
  localparam int unsigned RotationCount = 30;
  localparam longint QuarterTurn = 64'sd1686629713;
  localparam longint ArcTanLut [10] = '{
    64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159, 64'sd67021687,
    64'sd33543516, 64'sd16775851, 64'sd8388437, 64'sd4194283, 64'sd2097149
  };
  // Both parts are scaled up until the larger one reaches 2^40 before rotating.
  localparam int unsigned ScaleExp = 40;

  localparam int unsigned RandomBins = 1150;
  localparam int unsigned MaxGap = 12;
  localparam int unsigned DrainCycles = total_latency(SW) + 8;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ReportLimit = 10;

  localparam logic signed [SW-1:0] SampleMax = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SampleMin = {1'b1, {(SW-1){1'b0}}};

  typedef struct {
    logic signed [SW-1:0] re;
    logic signed [SW-1:0] im;
    logic last;
  } bin_t;

  typedef struct {
    logic [SW-1:0] mag;
    logic signed [PW-1:0] phase;
    logic last;
  } polar_t;

  // Shapes of random bins. Full-range values toggle every bit, the rest aim at
  // small vectors, the axes, the diagonals, the extreme corners and bins with one tiny part.
  typedef enum int unsigned {
    ShapeFull,
    ShapeSmall,
    ShapeAxis,
    ShapeDiagonal,
    ShapeCorner,
    ShapeLopsided
  } bin_shape_e;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  logic signed [SW-1:0] real_part_i;
  logic signed [SW-1:0] imag_part_i;
  logic last_bin_i;
  logic done_o;
  logic [SW-1:0] magnitude_o;
  logic signed [PW-1:0] phase_o;
  logic last_out_o;

  bin_t bin_q[$];
  polar_t polar_expect_q[$];
  int unsigned bins_total;
  int unsigned bins_taken;
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned gap_left;
  logic burst_mode;
  logic took_bin;

  complex_bin_magnitude_phase #(
    .SAMPLE_WIDTH(SW),
    .ANGLE_FRAC_BITS(AFB)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .busy_o(busy_o),
    .real_part_i(real_part_i),
    .imag_part_i(imag_part_i),
    .last_bin_i(last_bin_i),
    .done_o(done_o),
    .magnitude_o(magnitude_o),
    .phase_o(phase_o),
    .last_out_o(last_out_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Polar form of one bin. The magnitude is an exact integer square root found
  // one result bit at a time. The phase is atan(im/re), not a four-quadrant
  // angle: a bin with a negative real part is mirrored through the origin
  // first, which leaves the ratio unchanged, and then rotated onto the
  // positive real axis while the rotation angles are summed. The sum is
  // rounded to the output scale with ties going away from zero.
  function automatic polar_t polar_of(bin_t b);
    longint re, im, ar, ai, x, y, z, m, dx, dy, step;
    longint unsigned rem, root, probe;
    polar_t r;
    re = b.re;
    im = b.im;
    ar = (re < 0) ? -re : re;
    ai = (im < 0) ? -im : im;
    rem = ar * ar + ai * ai;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    r.mag = root[SW-1:0];

    z = 0;
    if (im == 0) begin
      // A purely real bin, the zero bin included, has phase zero.
      z = 0;
    end else if (re == 0) begin
      // A purely imaginary bin gives +pi/2 whichever sign the imaginary part has.
      z = QuarterTurn;
    end else begin
      x = re;
      y = im;
      if (x < 0) begin
        x = -x;
        y = -y;
      end
      m = (x > ai) ? x : ai;
      while (m < (64'sd1 << ScaleExp)) begin
        x = x * 2;
        y = y * 2;
        m = m * 2;
      end
      for (int i = 0; i < RotationCount; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        step = (i < 10) ? ArcTanLut[i] : (64'sd1 <<< (AngleUnitBits - i));
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + step;
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - step;
        end
      end
    end

    m = (z < 0) ? -z : z;
    m = (m + (64'sd1 <<< (AngleUnitBits - AFB - 1))) >>> (AngleUnitBits - AFB);
    if (z < 0) m = -m;
    r.phase = m[PW-1:0];
    r.last = b.last;
    return r;
  endfunction

  function automatic logic signed [SW-1:0] span_value(int unsigned lim);
    return $signed(SW'($urandom_range(0, 2 * lim))) - $signed(SW'(lim));
  endfunction

  function automatic bin_t random_bin();
    bin_t b;
    bin_shape_e shape;
    int unsigned draw;
    draw = $urandom_range(0, 99);
    if (draw < 40) shape = ShapeFull;
    else if (draw < 60) shape = ShapeSmall;
    else if (draw < 70) shape = ShapeAxis;
    else if (draw < 80) shape = ShapeDiagonal;
    else if (draw < 88) shape = ShapeCorner;
    else shape = ShapeLopsided;
    b.re = SW'($urandom());
    b.im = SW'($urandom());
    case (shape)
      ShapeSmall: begin
        b.re = span_value(300);
        b.im = span_value(300);
      end
      ShapeAxis: begin
        if ($urandom_range(0, 1) == 1) b.re = '0;
        else b.im = '0;
      end
      ShapeDiagonal: begin
        // Equal or opposite parts put the angle right on +-pi/4.
        b.im = ($urandom_range(0, 1) == 1) ? b.re : -b.re;
      end
      ShapeCorner: begin
        b.re = ($urandom_range(0, 1) == 1) ? SampleMin : SampleMax;
        if ($urandom_range(0, 1) == 1) b.im = ($urandom_range(0, 1) == 1) ? SampleMin : SampleMax;
      end
      ShapeLopsided: begin
        if ($urandom_range(0, 1) == 1) b.re = span_value(3);
        else b.im = span_value(3);
      end
      default: begin
      end
    endcase
    b.last = ($urandom_range(0, 7) == 0);
    return b;
  endfunction

  task automatic queue_bin(logic signed [SW-1:0] re, logic signed [SW-1:0] im, logic last);
    bin_t b;
    b.re = re;
    b.im = im;
    b.last = last;
    bin_q.push_back(b);
  endtask

  // The driver works on the falling edge. A bin on the bus stays there until a
  // rising edge has taken it; then the sender either idles for the gap drawn
  // for the next bin or puts that bin on the bus at once. Bursts with no gaps
  // at all alternate with stretches of random gaps.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!start_i || took_bin) begin
        if (gap_left > 0) begin
          start_i <= 1'b0;
          gap_left = gap_left - 1;
        end else if (bin_q.size() > 0) begin
          bin_t b;
          b = bin_q.pop_front();
          real_part_i <= b.re;
          imag_part_i <= b.im;
          last_bin_i <= b.last;
          start_i <= 1'b1;
          if ($urandom_range(0, 31) == 0) burst_mode = ~burst_mode;
          gap_left = burst_mode ? 0 : $urandom_range(0, MaxGap);
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // The monitor samples on the rising edge. It checks any result against the
  // oldest expectation and records the expected polar form of every bin taken
  // in this cycle.
  always @(posedge clk_i) begin
    took_bin = 1'b0;
    if (rst_ni) begin
      if (done_o) begin
        if (polar_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("unexpected result: mag=%0d phase=%0d last=%0b",
                     magnitude_o, phase_o, last_out_o);
        end else begin
          polar_t want;
          want = polar_expect_q.pop_front();
          if (magnitude_o !== want.mag || phase_o !== want.phase || last_out_o !== want.last) begin
            mismatches++;
            if (mismatches <= ReportLimit)
              $display("mismatch: expected mag=%0d phase=%0d last=%0b, got mag=%0d phase=%0d last=%0b",
                       want.mag, want.phase, want.last, magnitude_o, phase_o, last_out_o);
          end
        end
      end
      if (start_i && !busy_o) begin
        bin_t b;
        b.re = real_part_i;
        b.im = imag_part_i;
        b.last = last_bin_i;
        polar_expect_q.push_back(polar_of(b));
        bins_taken++;
        took_bin = 1'b1;
      end
    end
  end

  // A hung block ends the run here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_complex_bin_magnitude_phase: FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    real_part_i = '0;
    imag_part_i = '0;
    last_bin_i = 1'b0;
    bins_taken = 0;
    mismatches = 0;
    cycles = 0;
    gap_left = 0;
    burst_mode = 1'b0;
    took_bin = 1'b0;

    // Directed bins: the zero bin, both axes with both signs, the extremes of
    // both parts, the diagonals and unit steps around the origin.
    queue_bin('0, '0, 1'b0);
    queue_bin('0, 24'sd5, 1'b1);
    queue_bin('0, -24'sd5, 1'b0);
    queue_bin(24'sd5, '0, 1'b0);
    queue_bin(-24'sd5, '0, 1'b1);
    queue_bin(SampleMax, SampleMax, 1'b0);
    queue_bin(SampleMin, SampleMin, 1'b1);
    queue_bin(SampleMin, SampleMax, 1'b0);
    queue_bin(SampleMax, SampleMin, 1'b0);
    queue_bin(SampleMin, '0, 1'b0);
    queue_bin('0, SampleMin, 1'b1);
    queue_bin('0, SampleMax, 1'b0);
    queue_bin(SampleMax, '0, 1'b0);
    queue_bin(24'sd1, 24'sd1, 1'b0);
    queue_bin(-24'sd1, 24'sd1, 1'b1);
    queue_bin(24'sd1, -24'sd1, 1'b0);
    queue_bin(-24'sd1, -24'sd1, 1'b0);
    queue_bin(SampleMin, 24'sd1, 1'b0);
    queue_bin(24'sd1, SampleMin, 1'b1);
    queue_bin(-24'sd1, SampleMax, 1'b0);
    queue_bin(SampleMax, -24'sd1, 1'b0);
    queue_bin(24'sd3, 24'sd4, 1'b1);
    for (int n = 0; n < RandomBins; n++) bin_q.push_back(random_bin());
    bins_total = bin_q.size();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (bins_taken < bins_total) @(posedge clk_i);
    while (polar_expect_q.size() != 0) @(posedge clk_i);
    // A short tail catches results that arrive with nothing left to expect.
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && polar_expect_q.size() == 0) begin
      $display("tb_complex_bin_magnitude_phase: PASS");
    end else begin
      $display("tb_complex_bin_magnitude_phase: FAIL");
    end
    $finish;
  end

endmodule
